/* rtl/decimal_integer_text_parser_unit_defines.svh */
// ---------------------------------------------------------------------------
// decimal integer text parser assertion macros
// shared property forms used by the parser rtl, all clocked on i_clk and
// disabled while i_rst_n is low
// ---------------------------------------------------------------------------
`ifndef DECIMAL_INTEGER_TEXT_PARSER_UNIT_DEFINES_SVH
`define DECIMAL_INTEGER_TEXT_PARSER_UNIT_DEFINES_SVH

// same-cycle implication
`define DTP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DTP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/dtp_pkg.sv */
// ---------------------------------------------------------------------------
// dtp_pkg
// types and constants shared by the decimal integer text parser
// ---------------------------------------------------------------------------
`default_nettype none

package dtp_pkg;

    // result value width at the ports
    localparam int unsigned OUT_VALUE_W = 64;

    // character codes
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;
    localparam logic [7:0] CHAR_LF    = 8'h0A;

    // lookahead modes
    localparam logic [1:0] LA_NONE  = 2'd0;
    localparam logic [1:0] LA_SPACE = 2'd1;
    localparam logic [1:0] LA_ALL   = 2'd2;

    // register indexes
    localparam logic REG_LOOKAHEAD = 1'b0;
    localparam logic REG_IGNORE    = 1'b1;

    // register reset values
    localparam logic [1:0] LOOKAHEAD_RST = LA_SPACE;
    localparam logic [7:0] IGNORE_RST    = CHAR_SPACE;

    typedef struct packed {
        logic [7:0] char_code;
        logic       timed_out;
    } t_in_item;

    typedef struct packed {
        logic signed [OUT_VALUE_W-1:0] value;
        logic                          number_found;
        logic                          char_left;
    } t_out_item;

    typedef struct packed {
        logic [1:0] lookahead_mode;
        logic [7:0] ignore_char;
    } t_cfg;

endpackage

`default_nettype wire

/* rtl/dtp_cfg_regs.sv */
// ---------------------------------------------------------------------------
// dtp_cfg_regs
// configuration registers of the parser, written through a plain write port
// ---------------------------------------------------------------------------
`default_nettype none

module dtp_cfg_regs
    import dtp_pkg::*;
(
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    output t_cfg            o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // register write decode
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (i_cfg_index)
                REG_LOOKAHEAD: n_cfg.lookahead_mode = i_cfg_data[1:0];
                REG_IGNORE:    n_cfg.ignore_char    = i_cfg_data;
                default: ;
            endcase
        end
    end

    // register storage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.lookahead_mode <= LOOKAHEAD_RST;
            r_cfg.ignore_char    <= IGNORE_RST;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

/* rtl/dtp_parse_core.sv */
// ---------------------------------------------------------------------------
// dtp_parse_core
// parse state and per-character decision: seek, accumulate or end a number
// ---------------------------------------------------------------------------
`default_nettype none
`include "decimal_integer_text_parser_unit_defines.svh"

module dtp_parse_core
    import dtp_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 64
) (
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire t_cfg     i_cfg,
    input  wire t_in_item i_item,
    input  wire logic     i_advance,
    output logic          o_res_valid,
    output t_out_item     o_res_item
);

    logic                   r_in_number;
    logic [VALUE_WIDTH-1:0] r_acc;
    logic                   r_neg;
    logic                   n_in_number;
    logic [VALUE_WIDTH-1:0] n_acc;
    logic                   n_neg;

    logic                          is_digit;
    logic                          is_minus;
    logic                          is_ignore;
    logic                          is_space;
    logic [VALUE_WIDTH-1:0]        acc_mac;
    logic signed [VALUE_WIDTH-1:0] signed_val;

    // character classes
    assign is_digit  = (i_item.char_code >= CHAR_ZERO) && (i_item.char_code <= CHAR_NINE);
    assign is_minus  = (i_item.char_code == CHAR_MINUS);
    assign is_ignore = (i_item.char_code == i_cfg.ignore_char);
    assign is_space  = (i_item.char_code == CHAR_SPACE) || (i_item.char_code == CHAR_TAB)
                    || (i_item.char_code == CHAR_CR) || (i_item.char_code == CHAR_LF);

    // acc * 10 + digit, wrapping at the accumulator width
    assign acc_mac = (r_acc << 3) + (r_acc << 1) + VALUE_WIDTH'(i_item.char_code[3:0]);

    // signed result before sign extension to the port width
    assign signed_val = r_neg ? signed'(-r_acc) : signed'(r_acc);

    // next state and result
    always_comb begin
        n_in_number             = r_in_number;
        n_acc                   = r_acc;
        n_neg                   = r_neg;
        o_res_valid             = 1'b0;
        o_res_item.value        = '0;
        o_res_item.number_found = 1'b0;
        o_res_item.char_left    = 1'b0;

        if (!r_in_number) begin
            if (i_item.timed_out) begin
                o_res_valid = 1'b1;
            end else if (is_minus || is_digit) begin
                n_in_number = 1'b1;
                if (!is_ignore) begin
                    if (is_minus) begin
                        n_neg = 1'b1;
                    end else begin
                        n_acc = acc_mac;
                    end
                end
            end else begin
                unique case (i_cfg.lookahead_mode)
                    LA_NONE: begin
                        o_res_valid          = 1'b1;
                        o_res_item.char_left = 1'b1;
                    end
                    LA_SPACE: begin
                        if (!is_space) begin
                            o_res_valid          = 1'b1;
                            o_res_item.char_left = 1'b1;
                        end
                    end
                    // skip everything, the unused code behaves the same
                    default: ;
                endcase
            end
        end else begin
            if (!i_item.timed_out && (is_digit || is_ignore)) begin
                if (!is_ignore) begin
                    n_acc = acc_mac;
                end
            end else begin
                o_res_valid             = 1'b1;
                o_res_item.value        = OUT_VALUE_W'(signed_val);
                o_res_item.number_found = 1'b1;
                o_res_item.char_left    = !i_item.timed_out;
            end
        end

        // every result returns the parser to seeking
        if (o_res_valid) begin
            n_in_number = 1'b0;
            n_acc       = '0;
            n_neg       = 1'b0;
        end
    end

    // parse state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_number <= 1'b0;
            r_acc       <= '0;
            r_neg       <= 1'b0;
        end else if (i_advance) begin
            r_in_number <= n_in_number;
            r_acc       <= n_acc;
            r_neg       <= n_neg;
        end
    end

    `DTP_ASSERT_NOW(a_seek_clear, !r_in_number, (r_acc == '0) && !r_neg,
        "number state not cleared while seeking")
    `DTP_ASSERT_NEXT(a_result_to_seek, i_advance && o_res_valid, !r_in_number,
        "parser did not return to seeking after a result")
    `DTP_ASSERT_NOW(a_no_number_zero, o_res_valid && !o_res_item.number_found,
        o_res_item.value == '0, "nonzero value without a number")

endmodule

`default_nettype wire

/* rtl/decimal_integer_text_parser_unit.sv */
// ---------------------------------------------------------------------------
// decimal_integer_text_parser_unit
// signed decimal integer parser over a stream of characters and timeouts
// ---------------------------------------------------------------------------
// One item (a character or a timeout event) is taken per clock cycle, except
// while a stalled output holds the input stage. An accepted item sits in an
// input register, where the parse logic classifies it and updates the
// accumulator; any result is loaded into an output register at the clock
// edge that moves the item on, and shows on o_out_valid from then on.
// The cycle
// time is set by the multiply-by-ten-and-add of the accumulator, a
// VALUE_WIDTH-bit three-operand add. A stalled output only holds the input
// stage when the item there produces a result. The block needs no start-up
// time after reset.
`default_nettype none
`include "decimal_integer_text_parser_unit_defines.svh"

module decimal_integer_text_parser_unit
    import dtp_pkg::*;
#(
    parameter int unsigned VALUE_WIDTH = 64
) (
    input  wire logic       i_clk,
    input  wire logic       i_rst_n,
    // configuration write port
    input  wire logic       i_cfg_we,
    input  wire logic       i_cfg_index,
    input  wire logic [7:0] i_cfg_data,
    // input channel
    input  wire logic       i_in_valid,
    output logic            o_in_ready,
    input  wire t_in_item   i_in_item,
    // output channel
    output logic            o_out_valid,
    input  wire logic       i_out_ready,
    output t_out_item       o_out_item
);

    t_cfg      cfg;
    logic      r_in_valid;
    t_in_item  r_in_item;
    logic      r_out_valid;
    t_out_item r_out_item;
    logic      res_valid;
    t_out_item res_item;
    logic      advance;

    // configuration
    dtp_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    // parse logic on the registered item
    dtp_parse_core #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_parse_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (cfg),
        .i_item      (r_in_item),
        .i_advance   (advance),
        .o_res_valid (res_valid),
        .o_res_item  (res_item)
    );

    // the staged item moves on unless its result meets a stalled output
    assign advance    = r_in_valid && (!res_valid || !r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_item <= i_in_item;
        end
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance && res_valid) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance && res_valid) begin
            r_out_item <= res_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    `DTP_ASSERT_NOW(a_no_overwrite, advance && res_valid, !r_out_valid || i_out_ready,
        "result loaded over an unaccepted result")
    `DTP_ASSERT_NOW(a_empty_stage_ready, !r_in_valid, o_in_ready,
        "input stage empty but not ready")
    `DTP_ASSERT_NEXT(a_stall_holds, r_out_valid && !i_out_ready, r_out_valid,
        "result dropped while stalled")

endmodule

`default_nettype wire
